// ===== hw/rtl/jafc_pkg.sv =====
`default_nettype none
package jafc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int AXIS_W      = SAMPLE_BITS + 1;
    localparam int LIMIT_W     = 16;
    localparam int NORM_W      = 16;
    localparam int CH_W        = 3;
    localparam int OP_W        = 2;

    // One unit of the normalized scale spans min to max over 2**SPAN_SHIFT.
    localparam int SPAN_SHIFT  = 10;
    localparam int DIFF_W      = LIMIT_W + 2;
    localparam int DEN_W       = LIMIT_W + 1;
    localparam int NUM_MAG_W   = LIMIT_W + SPAN_SHIFT;
    localparam int DIV_STEPS   = NUM_MAG_W;
    localparam int CNT_W       = $clog2(DIV_STEPS + 1);

    localparam logic [AXIS_W-1:0]  FULL_SCALE  = {1'b1, {SAMPLE_BITS{1'b0}}};
    localparam logic [LIMIT_W-1:0] LIMIT_TOP   = {LIMIT_W{1'b1}};
    localparam logic [NUM_MAG_W-1:0] NORM_POS_LIMIT = NUM_MAG_W'(32767);
    localparam logic [NUM_MAG_W-1:0] NORM_NEG_LIMIT = NUM_MAG_W'(32768);
    localparam logic signed [NORM_W-1:0] NORM_POS_SAT = 16'sh7FFF;
    localparam logic signed [NORM_W-1:0] NORM_NEG_SAT = -16'sh8000;
    localparam logic signed [NORM_W-1:0] NORM_EQUAL   = -16'sd4096;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE    = 2'd0,
        OP_BEGIN_CAL = 2'd1,
        OP_END_CAL   = 2'd2,
        OP_LOAD      = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_TRACK,
        ST_SETUP,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic [CH_W-1:0]          channel;
        logic [SAMPLE_BITS-1:0]   sample;
        logic [LIMIT_W-1:0]       load_min;
        logic [LIMIT_W-1:0]       load_max;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]          channel_out;
        logic [AXIS_W-1:0]        axis_value;
        logic signed [NORM_W-1:0] normalized;
        logic [LIMIT_W-1:0]       limit_min;
        logic [LIMIT_W-1:0]       limit_max;
        logic                     calibrating;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic track;
        logic setup;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/joystick_axis_filter_calibrate_unit.sv =====
// Each item passes the update, track, setup, divide and write states; write waits only on a stalled result.
// A new input is taken only once the item, with its 26-step restoring divide, is done.
// A finished result sits in the output register while the next input transfer is taken.
// Reset (aresetn, synchronous, active low) clears filters to 0, minimums to 0xFFFF,
// maximums to 0, calibration tracking off and the roll channel select to 0.
`default_nettype none
module joystick_axis_filter_calibrate_unit #(
    parameter int NUM_AXES = 5
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Input channel: one command or sample per transfer.
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire jafc_pkg::in_item_t        s_data,
    // Result channel: one result per input item.
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output jafc_pkg::out_item_t            m_data,
    // Roll channel select; the user must write it only while the block is idle, the block does not enforce this.
    input  wire logic                      cfg_wr_en,
    input  wire logic [jafc_pkg::CH_W-1:0] cfg_wr_data
);

    // The controller walks each item through update, limit tracking,
    // divider setup, the division itself and the final result write.
    // The datapath owns all per-channel state and the divider registers.
    jafc_pkg::cmd_t    cmd;
    jafc_pkg::status_t status;

    jafc_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The filter update and the limit widening happen in separate cycles so
    // that tracking compares against the freshly filtered, reported value.
    jafc_datapath #(
        .NUM_AXES (NUM_AXES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_data      (m_data)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/jafc_datapath.sv =====
`default_nettype none
module jafc_datapath #(
    parameter int NUM_AXES = 5
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire jafc_pkg::cmd_t            cmd,
    output jafc_pkg::status_t              status,
    input  wire jafc_pkg::in_item_t        s_data,
    input  wire logic                      cfg_wr_en,
    input  wire logic [jafc_pkg::CH_W-1:0] cfg_wr_data,
    output jafc_pkg::out_item_t            m_data
);

    localparam int SW = jafc_pkg::SAMPLE_BITS;
    localparam int LW = jafc_pkg::LIMIT_W;
    localparam int AW = jafc_pkg::AXIS_W;
    localparam int NW = jafc_pkg::NUM_MAG_W;

    logic [SW-1:0] filt_reg [NUM_AXES];
    logic [SW-1:0] filt_next [NUM_AXES];
    logic [LW-1:0] min_reg [NUM_AXES];
    logic [LW-1:0] min_next [NUM_AXES];
    logic [LW-1:0] max_reg [NUM_AXES];
    logic [LW-1:0] max_next [NUM_AXES];
    logic          tracking_reg, tracking_next;
    logic [jafc_pkg::CH_W-1:0] roll_reg, roll_next;

    jafc_pkg::in_item_t  item_reg, item_next;
    jafc_pkg::out_item_t out_reg, out_next;

    logic [LW-1:0]  rem_reg, rem_next;
    logic [NW-1:0]  quo_reg, quo_next;
    logic [LW-1:0]  den_reg, den_next;
    logic           neg_reg, neg_next;
    logic           zero_reg, zero_next;
    logic [jafc_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic [NUM_AXES-1:0] sel;
    logic                ch_ok;
    logic [SW-1:0]       f_cur;
    logic [LW-1:0]       lo_cur;
    logic [LW-1:0]       hi_cur;
    logic [SW+1:0]       filt_sum;
    logic [AW-1:0]       rep;
    logic [LW-1:0]       rep_wide;
    logic signed [jafc_pkg::DIFF_W-1:0] diff;
    logic [jafc_pkg::DIFF_W-1:0]        diff_abs;
    logic signed [jafc_pkg::DEN_W-1:0]  den;
    logic [jafc_pkg::DEN_W-1:0]         den_abs;
    logic [LW:0]         trial;
    logic [LW:0]         shifted;
    logic signed [jafc_pkg::NORM_W-1:0] norm;

    // Channel decode and read of the addressed channel's state.
    always_comb begin
        ch_ok  = (32'(item_reg.channel) < NUM_AXES);
        f_cur  = '0;
        lo_cur = '0;
        hi_cur = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            sel[i] = ch_ok && (32'(item_reg.channel) == i);
            if (sel[i]) begin
                f_cur  = filt_reg[i];
                lo_cur = min_reg[i];
                hi_cur = max_reg[i];
            end
        end
        rep = (item_reg.channel == roll_reg) ? (jafc_pkg::FULL_SCALE - {1'b0, f_cur})
                                             : {1'b0, f_cur};
        rep_wide = LW'(rep);
        filt_sum = {2'b00, f_cur} + {1'b0, f_cur, 1'b0} + {2'b00, item_reg.sample}
                 + (SW+2)'(2);
    end

    // State updates for filter, limits, tracking flag and roll channel select.
    always_comb begin
        filt_next     = filt_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        tracking_next = tracking_reg;
        roll_next     = cfg_wr_en ? cfg_wr_data : roll_reg;
        if (cmd.update) begin
            case (item_reg.opcode)
                jafc_pkg::OP_BEGIN_CAL: begin
                    tracking_next = 1'b1;
                    for (int i = 0; i < NUM_AXES; i++) begin
                        min_next[i] = jafc_pkg::LIMIT_TOP;
                        max_next[i] = '0;
                    end
                end
                jafc_pkg::OP_END_CAL: begin
                    tracking_next = 1'b0;
                end
                jafc_pkg::OP_LOAD: begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        if (sel[i]) begin
                            min_next[i] = item_reg.load_min;
                            max_next[i] = item_reg.load_max;
                        end
                    end
                end
                jafc_pkg::OP_SAMPLE: begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        if (sel[i]) begin
                            filt_next[i] = filt_sum[SW+1:2];
                        end
                    end
                end
                default: begin
                    tracking_next = tracking_reg;
                end
            endcase
        end
        if (cmd.track && tracking_reg && (item_reg.opcode == jafc_pkg::OP_SAMPLE)) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                if (sel[i]) begin
                    if (rep_wide > max_reg[i]) begin
                        max_next[i] = rep_wide;
                    end
                    if (rep_wide < min_reg[i]) begin
                        min_next[i] = rep_wide;
                    end
                end
            end
        end
    end

    // Input capture and divider: sign and magnitude setup, then one restoring step per cycle.
    always_comb begin
        diff     = $signed(jafc_pkg::DIFF_W'(rep)) - $signed({2'b00, lo_cur});
        diff_abs = diff[jafc_pkg::DIFF_W-1] ? jafc_pkg::DIFF_W'(-diff)
                                            : jafc_pkg::DIFF_W'(diff);
        den      = $signed({1'b0, hi_cur}) - $signed({1'b0, lo_cur});
        den_abs  = den[jafc_pkg::DEN_W-1] ? jafc_pkg::DEN_W'(-den) : jafc_pkg::DEN_W'(den);
        shifted  = {rem_reg, quo_reg[NW-1]};
        trial    = shifted - {1'b0, den_reg};

        item_next = cmd.capture ? s_data : item_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        if (cmd.setup) begin
            rem_next  = '0;
            quo_next  = {diff_abs[LW-1:0], {jafc_pkg::SPAN_SHIFT{1'b0}}};
            den_next  = den_abs[LW-1:0];
            neg_next  = diff[jafc_pkg::DIFF_W-1] ^ den[jafc_pkg::DEN_W-1];
            zero_next = (hi_cur == lo_cur);
            cnt_next  = '0;
        end else if (cmd.div_step) begin
            if (!trial[LW]) begin
                rem_next = trial[LW-1:0];
            end else begin
                rem_next = shifted[LW-1:0];
            end
            quo_next = {quo_reg[NW-2:0], ~trial[LW]};
            cnt_next = cnt_reg + 1'b1;
        end
        status.div_last = (cnt_reg == jafc_pkg::CNT_W'(jafc_pkg::DIV_STEPS - 1));
    end

    // Saturation of the quotient and assembly of the result.
    always_comb begin
        if (zero_reg) begin
            norm = jafc_pkg::NORM_EQUAL;
        end else if (neg_reg) begin
            norm = (quo_reg > jafc_pkg::NORM_NEG_LIMIT) ? jafc_pkg::NORM_NEG_SAT
                                                         : -$signed(quo_reg[LW-1:0]);
        end else begin
            norm = (quo_reg > jafc_pkg::NORM_POS_LIMIT) ? jafc_pkg::NORM_POS_SAT
                                                         : $signed(quo_reg[LW-1:0]);
        end
        out_next = out_reg;
        if (cmd.load_out) begin
            out_next.channel_out = item_reg.channel;
            out_next.calibrating = tracking_reg;
            if (ch_ok) begin
                out_next.axis_value = rep;
                out_next.normalized = norm;
                out_next.limit_min  = lo_cur;
                out_next.limit_max  = hi_cur;
            end else begin
                out_next.axis_value = '0;
                out_next.normalized = '0;
                out_next.limit_min  = '0;
                out_next.limit_max  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                filt_reg[i] <= '0;
                min_reg[i]  <= jafc_pkg::LIMIT_TOP;
                max_reg[i]  <= '0;
            end
            tracking_reg <= 1'b0;
            roll_reg     <= '0;
            cnt_reg      <= '0;
        end else begin
            filt_reg     <= filt_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            tracking_reg <= tracking_next;
            roll_reg     <= roll_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        out_reg  <= out_next;
    end

    assign m_data = out_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/jafc_controller.sv =====
`default_nettype none
module jafc_controller (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire jafc_pkg::status_t  status,
    output jafc_pkg::cmd_t          cmd
);

    jafc_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            jafc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = jafc_pkg::ST_UPDATE;
                end
            end
            jafc_pkg::ST_UPDATE: state_next = jafc_pkg::ST_TRACK;
            jafc_pkg::ST_TRACK:  state_next = jafc_pkg::ST_SETUP;
            jafc_pkg::ST_SETUP:  state_next = jafc_pkg::ST_DIVIDE;
            jafc_pkg::ST_DIVIDE: begin
                if (status.div_last) begin
                    state_next = jafc_pkg::ST_WRITE;
                end
            end
            jafc_pkg::ST_WRITE: begin
                if (out_free) begin
                    state_next = jafc_pkg::ST_IDLE;
                end
            end
            default: state_next = jafc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            jafc_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            jafc_pkg::ST_UPDATE: cmd.update   = 1'b1;
            jafc_pkg::ST_TRACK:  cmd.track    = 1'b1;
            jafc_pkg::ST_SETUP:  cmd.setup    = 1'b1;
            jafc_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
            jafc_pkg::ST_WRITE:  cmd.load_out = out_free;
            default:             cmd          = '0;
        endcase
        out_valid_next = cmd.load_out ? 1'b1 : (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= jafc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/jafc_checker.sv =====
`default_nettype none
module jafc_checker #(
    parameter int NUM_AXES = 5
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire jafc_pkg::out_item_t m_data
);

    logic out_ch_ok;
    assign out_ch_ok = (32'(m_data.channel_out) < NUM_AXES);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Only one item is in flight: the block is busy right after a transfer.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // Out of range channels report zeros.
    a_bad_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !out_ch_ok |-> m_data.axis_value == '0 && m_data.normalized == '0
            && m_data.limit_min == '0 && m_data.limit_max == '0)
        else $error("out of range channel gave nonzero fields");

    // Equal limits give the fixed marker value.
    a_equal_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && out_ch_ok && m_data.limit_min == m_data.limit_max
            |-> m_data.normalized == jafc_pkg::NORM_EQUAL)
        else $error("equal limits without marker value");

    // The reported axis value never exceeds full scale.
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.axis_value <= jafc_pkg::FULL_SCALE)
        else $error("axis value above full scale");

endmodule

bind joystick_axis_filter_calibrate_unit jafc_checker #(
    .NUM_AXES (NUM_AXES)
) u_jafc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
